@@ rtl/core/aqts_pkg.sv @@
// Shared codes for the two-stack aggregate queue: requested actions,
// aggregate operations and result status. No dependencies.
package aqts_pkg;

  localparam int ActionWidth = 2;
  localparam int OpWidth     = 3;
  localparam int StatusWidth = 2;
  localparam int CountWidth  = 7;
  localparam int PortWidth   = 32;

  localparam logic [ActionWidth-1:0] ACT_PUSH = 2'd0;
  localparam logic [ActionWidth-1:0] ACT_POP  = 2'd1;
  localparam logic [ActionWidth-1:0] ACT_PEEK = 2'd2;

  localparam logic [OpWidth-1:0] OP_MIN = 3'd0;
  localparam logic [OpWidth-1:0] OP_MAX = 3'd1;
  localparam logic [OpWidth-1:0] OP_SUM = 3'd2;
  localparam logic [OpWidth-1:0] OP_AND = 3'd3;
  localparam logic [OpWidth-1:0] OP_OR  = 3'd4;
  localparam logic [OpWidth-1:0] OP_XOR = 3'd5;

  localparam logic [StatusWidth-1:0] STATUS_OK    = 2'd0;
  localparam logic [StatusWidth-1:0] STATUS_EMPTY = 2'd1;
  localparam logic [StatusWidth-1:0] STATUS_FULL  = 2'd2;

endpackage

@@ rtl/core/aggregate_queue_two_stack_unit.sv @@
// Top level of the two-stack aggregate queue.
// Depends on aqts_pkg and aqts_combine.

// A FIFO of signed values that reports, with every request, the front value,
// the configured aggregate over all held values, the count and a status.
// The state lives in two single-port-style stack memories (input and output
// stack), each entry holding a value and the prefix aggregate of its stack;
// the tops are cached in registers. A push, a peek or a pop on an empty queue
// goes straight to the finish state. Any other pop passes through the pop
// state, then the pop-read state when the output stack still holds values
// after it, to reload its cached top; when the output stack is empty it first
// moves the input stack over at one entry per cycle through the input stack
// read port. A finished result waits in the output register; the next request
// can be taken only once the current one has handed its result over.
module aggregate_queue_two_stack_unit #(
  parameter int QUEUE_DEPTH = 64,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_wr_en,
  input  logic [aqts_pkg::OpWidth-1:0]          cfg_wr_data,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [aqts_pkg::ActionWidth-1:0]      action,
  input  logic signed [aqts_pkg::PortWidth-1:0] push_value,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [aqts_pkg::PortWidth-1:0] front_value,
  output logic signed [aqts_pkg::PortWidth-1:0] window_aggregate,
  output logic [aqts_pkg::CountWidth-1:0]       held_count,
  output logic                                  is_empty,
  output logic [aqts_pkg::StatusWidth-1:0]      status
);

  localparam int ADDR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int ENTRY_W = 2 * VALUE_WIDTH;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_MOVE  = 5'b00010,
    ST_POP   = 5'b00100,
    ST_POPRD = 5'b01000,
    ST_FIN   = 5'b10000
  } state_t;

  state_t state;
  logic [aqts_pkg::OpWidth-1:0]     op_sel;
  logic [CNT_W-1:0]                 in_depth;
  logic [CNT_W-1:0]                 out_depth;
  logic [CNT_W-1:0]                 mv_left;
  logic                             mv_dv;
  logic signed [VALUE_WIDTH-1:0]    in_top_agg;
  logic signed [VALUE_WIDTH-1:0]    in_bottom;
  logic signed [VALUE_WIDTH-1:0]    out_top_val;
  logic signed [VALUE_WIDTH-1:0]    out_top_agg;
  logic [aqts_pkg::StatusWidth-1:0] status_q;

  logic [ENTRY_W-1:0] in_mem  [QUEUE_DEPTH];
  logic [ENTRY_W-1:0] out_mem [QUEUE_DEPTH];
  logic [ENTRY_W-1:0] in_rd_q;
  logic [ENTRY_W-1:0] out_rd_q;

  logic                          in_acc;
  logic                          out_free;
  logic                          moving;
  logic                          full;
  logic [CNT_W-1:0]              total;
  logic signed [VALUE_WIDTH-1:0] push_v;
  logic signed [VALUE_WIDTH-1:0] wr_val;
  logic signed [VALUE_WIDTH-1:0] comb_b;
  logic signed [VALUE_WIDTH-1:0] comb_y;
  logic signed [VALUE_WIDTH-1:0] push_agg;
  logic signed [VALUE_WIDTH-1:0] both_agg;
  logic signed [VALUE_WIDTH-1:0] res_front;
  logic signed [VALUE_WIDTH-1:0] res_agg;
  logic                          in_wr_en;
  logic                          in_rd_en;
  logic                          out_wr_en;
  logic                          out_rd_en;
  logic [CNT_W-1:0]              in_rd_idx;
  logic [CNT_W-1:0]              out_rd_idx;

  assign in_ready = (state == ST_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign moving   = (state == ST_MOVE);
  assign total    = in_depth + out_depth;
  assign full     = (total >= CNT_W'(QUEUE_DEPTH));
  assign push_v   = push_value[VALUE_WIDTH-1:0];

  // One combine unit serves both stack pushes: a request push onto the input
  // stack and each entry moved onto the output stack.
  assign wr_val = moving ? in_rd_q[VALUE_WIDTH-1:0] : push_v;
  assign comb_b = moving ? out_top_agg : in_top_agg;

  aqts_combine #(.VALUE_WIDTH(VALUE_WIDTH)) u_push_comb (
    .op (op_sel),
    .a  (wr_val),
    .b  (comb_b),
    .y  (comb_y)
  );

  always_comb begin
    if (moving) begin
      push_agg = (out_depth == '0) ? wr_val : comb_y;
    end else begin
      push_agg = (in_depth == '0) ? wr_val : comb_y;
    end
  end

  aqts_combine #(.VALUE_WIDTH(VALUE_WIDTH)) u_result_comb (
    .op (op_sel),
    .a  (in_top_agg),
    .b  (out_top_agg),
    .y  (both_agg)
  );

  always_comb begin
    res_front = '0;
    res_agg   = '0;
    if (total != '0) begin
      res_front = (out_depth != '0) ? out_top_val : in_bottom;
      if (out_depth == '0) begin
        res_agg = in_top_agg;
      end else if (in_depth == '0) begin
        res_agg = out_top_agg;
      end else begin
        res_agg = both_agg;
      end
    end
  end

  // Memory port controls.
  assign in_wr_en   = in_acc && (action == aqts_pkg::ACT_PUSH) && !full;
  assign in_rd_en   = moving && (mv_left != '0);
  assign in_rd_idx  = mv_left - CNT_W'(1);
  assign out_wr_en  = moving && mv_dv;
  assign out_rd_en  = (state == ST_POP) && (out_depth > CNT_W'(1));
  assign out_rd_idx = out_depth - CNT_W'(2);

  always_ff @(posedge clk) begin
    if (in_wr_en) begin
      in_mem[in_depth[ADDR_W-1:0]] <= {push_agg, push_v};
    end
    if (in_rd_en) begin
      in_rd_q <= in_mem[in_rd_idx[ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (out_wr_en) begin
      out_mem[out_depth[ADDR_W-1:0]] <= {push_agg, wr_val};
    end
    if (out_rd_en) begin
      out_rd_q <= out_mem[out_rd_idx[ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      op_sel    <= aqts_pkg::OP_MIN;
      in_depth  <= '0;
      out_depth <= '0;
      mv_left   <= '0;
      mv_dv     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        op_sel <= cfg_wr_data;
      end
      if ((state == ST_FIN) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_acc) begin
            state <= ST_FIN;
            case (action)
              aqts_pkg::ACT_PUSH: begin
                if (full) begin
                  status_q <= aqts_pkg::STATUS_FULL;
                end else begin
                  status_q   <= aqts_pkg::STATUS_OK;
                  in_depth   <= in_depth + CNT_W'(1);
                  in_top_agg <= push_agg;
                  if (in_depth == '0) begin
                    in_bottom <= push_v;
                  end
                end
              end
              aqts_pkg::ACT_POP: begin
                if (total == '0) begin
                  status_q <= aqts_pkg::STATUS_EMPTY;
                end else begin
                  status_q <= aqts_pkg::STATUS_OK;
                  if (out_depth == '0) begin
                    mv_left  <= in_depth;
                    in_depth <= '0;
                    state    <= ST_MOVE;
                  end else begin
                    state <= ST_POP;
                  end
                end
              end
              default: begin
                status_q <= (total == '0) ? aqts_pkg::STATUS_EMPTY : aqts_pkg::STATUS_OK;
              end
            endcase
          end
        end
        ST_MOVE: begin
          // Reads are registered in in_rd_q and each is written in the cycle after it;
          // the cached top aggregate forwards each new prefix to the next entry.
          mv_dv <= (mv_left != '0);
          if (mv_left != '0) begin
            mv_left <= mv_left - CNT_W'(1);
          end
          if (mv_dv) begin
            out_depth   <= out_depth + CNT_W'(1);
            out_top_val <= wr_val;
            out_top_agg <= push_agg;
          end
          if ((mv_left == '0) && !mv_dv) begin
            state <= ST_POP;
          end
        end
        ST_POP: begin
          out_depth <= out_depth - CNT_W'(1);
          state     <= (out_depth > CNT_W'(1)) ? ST_POPRD : ST_FIN;
        end
        ST_POPRD: begin
          out_top_val <= out_rd_q[VALUE_WIDTH-1:0];
          out_top_agg <= out_rd_q[ENTRY_W-1:VALUE_WIDTH];
          state       <= ST_FIN;
        end
        ST_FIN: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Result payload; loaded only when the output register is free.
  always_ff @(posedge clk) begin
    if ((state == ST_FIN) && out_free) begin
      front_value      <= aqts_pkg::PortWidth'(res_front);
      window_aggregate <= aqts_pkg::PortWidth'(res_agg);
      held_count       <= aqts_pkg::CountWidth'(total);
      is_empty         <= (total == '0);
      status           <= status_q;
    end
  end

endmodule

@@ rtl/core/aqts_combine.sv @@
// Aggregate operator of the queue: min, max, wrapping sum, and, or, xor.
// Depends on aqts_pkg for the operation codes.
module aqts_combine #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic [aqts_pkg::OpWidth-1:0] op,
  input  logic signed [VALUE_WIDTH-1:0] a,
  input  logic signed [VALUE_WIDTH-1:0] b,
  output logic signed [VALUE_WIDTH-1:0] y
);

  always_comb begin
    case (op)
      aqts_pkg::OP_MAX: y = (a > b) ? a : b;
      aqts_pkg::OP_SUM: y = a + b;
      aqts_pkg::OP_AND: y = a & b;
      aqts_pkg::OP_OR:  y = a | b;
      aqts_pkg::OP_XOR: y = a ^ b;
      // Unused codes fall back to min.
      default:          y = (a < b) ? a : b;
    endcase
  end

endmodule

@@ rtl/core/aqts_checker.sv @@
// Port-level checks for the two-stack aggregate queue, bound to the top level.
// Depends on aqts_pkg for the status codes.
module aqts_checker (
  input logic                                  clk,
  input logic                                  rst,
  input logic                                  out_valid,
  input logic                                  out_ready,
  input logic signed [aqts_pkg::PortWidth-1:0] front_value,
  input logic signed [aqts_pkg::PortWidth-1:0] window_aggregate,
  input logic [aqts_pkg::CountWidth-1:0]       held_count,
  input logic                                  is_empty,
  input logic [aqts_pkg::StatusWidth-1:0]      status
);

  // The empty flag and the count must agree on every result.
  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (is_empty == (held_count == '0)))
    else $error("is_empty disagrees with held_count");

  // An empty queue reports zero front and zero aggregate.
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && is_empty) |-> ((front_value == '0) && (window_aggregate == '0)))
    else $error("empty queue reports nonzero front or aggregate");

  // A rejected pop or peek leaves the queue empty; a dropped push means full.
  a_status_state: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status == aqts_pkg::STATUS_EMPTY)) |-> is_empty)
    else $error("empty status on a nonempty queue");

  a_full_nonempty: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status == aqts_pkg::STATUS_FULL)) |-> !is_empty)
    else $error("full status on an empty queue");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(front_value)
      && $stable(window_aggregate) && $stable(status)))
    else $error("stalled result changed");

endmodule

bind aggregate_queue_two_stack_unit aqts_checker u_aqts_checker (.*);
